/* rtl/pdz_pkg.sv */
// Package for the PID controller with dead band and integral separation.
// Holds fixed-point constants, command, status and register codes, state types
// and the saturation helpers used by the controller.
package pdz_pkg;

	localparam int FRAC_BITS = 16;

	localparam int MUL_A_W = 64;
	localparam int MUL_B_W = 32;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W;

	localparam int DIV_N_W = 64;
	localparam int DIV_D_W = 42;
	localparam int DIV_CNT_W = $clog2(DIV_N_W);

	localparam int MAG_W = 53;
	localparam logic [MAG_W-1:0] MAG_CAP = {1'b1, {(MAG_W-1){1'b0}}};

	localparam logic [15:0] MS_PER_S = 16'd1000;
	localparam logic [15:0] MS_DEFAULT = 16'd100;

	// ceil(2^51 / 125) split at bit 32: (x >> 3) * K >> 51 is x / 1000
	localparam logic [31:0] K1000_LO = 32'd1305670058;
	localparam logic [31:0] K1000_HI = 32'd4194;

	localparam logic [31:0] DMAX_RESET = 32'd6553600;
	localparam logic [30:0] SEP_RESET = 31'd1966080;
	localparam logic [30:0] DB_RESET = 31'd32768;

	typedef enum logic [1:0] {
		CMD_COMPUTE = 2'd0,
		CMD_MANUAL_DUTY = 2'd1,
		CMD_AUTO_RESET = 2'd2,
		CMD_MANUAL = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		STS_COMPUTED = 3'd0,
		STS_CLAMPED = 3'd1,
		STS_HELD_MANUAL = 3'd2,
		STS_HELD_DEAD = 3'd3,
		STS_APPLIED = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		REG_PROP_GAIN = 3'd0,
		REG_INTEG_GAIN = 3'd1,
		REG_DERIV_GAIN = 3'd2,
		REG_DRIVE_MAX = 3'd3,
		REG_DRIVE_MIN = 3'd4,
		REG_SEP_LIMIT = 3'd5,
		REG_DEAD_BAND = 3'd6
	} cfg_reg_t;

	typedef enum logic [1:0] {
		MS_IDLE,
		MS_LO,
		MS_HI,
		MS_SUM
	} mul_state_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_EM,
		ST_RLO,
		ST_RHI,
		ST_KI1K,
		ST_DM1K,
		ST_IMAX,
		ST_IT,
		ST_PT,
		ST_DG,
		ST_D1K,
		ST_DDIV,
		ST_SUM,
		ST_BC,
		ST_DONE
	} ctl_state_t;

	// (|x| * k) >> FRAC_BITS, magnitude capped at 2^52
	function automatic logic [MAG_W-1:0] gain_cap(input logic [MUL_P_W-1:0] p);
		logic [MUL_P_W-1:0] sh;
		sh = p >> FRAC_BITS;
		if (sh > MUL_P_W'(MAG_CAP))
			return MAG_CAP;
		return sh[MAG_W-1:0];
	endfunction

	function automatic logic signed [47:0] sat48(input logic signed [48:0] v);
		if (v[48] != v[47])
			return v[48] ? {1'b1, 47'b0} : {1'b0, {47{1'b1}}};
		return v[47:0];
	endfunction

endpackage

/* rtl/pdz_mul.sv */
// Shared multiplier: 64 x 32 unsigned product built from two 32 x 32 partials.
// Depends on pdz_pkg for widths and the sequencer state type.
module pdz_mul import pdz_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [MUL_A_W-1:0] a,
	input  logic [MUL_B_W-1:0] b,
	output logic               done,
	output logic [MUL_P_W-1:0] prod
);

	mul_state_t st_q, st_d;
	logic [MUL_A_W-1:0] a_q;
	logic [MUL_B_W-1:0] b_q;
	logic [63:0] pp_q;
	logic [MUL_P_W-1:0] acc_q;
	logic done_q;

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			MS_IDLE: if (start) st_d = MS_LO;
			MS_LO: st_d = MS_HI;
			MS_HI: st_d = MS_SUM;
			MS_SUM: st_d = MS_IDLE;
			default: st_d = MS_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= MS_IDLE;
			done_q <= 1'b0;
		end else begin
			st_q <= st_d;
			done_q <= (st_q == MS_SUM);
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			MS_IDLE: begin
				if (start) begin
					a_q <= a;
					b_q <= b;
				end
			end
			MS_LO: pp_q <= a_q[31:0] * b_q;
			MS_HI: begin
				acc_q <= {32'b0, pp_q};
				pp_q <= a_q[63:32] * b_q;
			end
			MS_SUM: acc_q <= acc_q + {pp_q, 32'b0};
			default: ;
		endcase
	end

	assign done = done_q;
	assign prod = acc_q;

endmodule

/* rtl/pdz_div.sv */
// Shared restoring divider, one quotient bit per cycle, unsigned operands.
// Depends on pdz_pkg for operand widths.
module pdz_div import pdz_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [DIV_N_W-1:0] num,
	input  logic [DIV_D_W-1:0] den,
	output logic               done,
	output logic [DIV_N_W-1:0] quo
);

	logic busy_q, done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DIV_N_W-1:0] num_q, quo_q;
	logic [DIV_D_W-1:0] den_q, rem_q;
	logic [DIV_D_W:0] rs, rdiff;
	logic take;

	assign rs = {rem_q, num_q[DIV_N_W-1]};
	assign rdiff = rs - {1'b0, den_q};
	assign take = (rs >= {1'b0, den_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == {DIV_CNT_W{1'b1}}) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= take ? rdiff[DIV_D_W-1:0] : rs[DIV_D_W-1:0];
			quo_q <= {quo_q[DIV_N_W-2:0], take};
			num_q <= {num_q[DIV_N_W-2:0], 1'b0};
		end
	end

	assign done = done_q;
	assign quo = quo_q;

endmodule

/* rtl/pid_deadzone_antiwindup.sv */
// Positional PID controller with dead band, integral separation and anti-windup.
// Commands 1-3 and held computes go from the input word through the done state to the
// output word. An active compute runs seven or nine multiplies, one or two divides, the
// sum, optional back-calculation and output. A waiting output word stalls it. One word
// at a time.
// Reset (arst_n low): gains zero, limits and bands at defaults, integral, error, drive zero.
module pid_deadzone_antiwindup import pdz_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [111:0] s_axis_tdata,  // target, measured, interval_ms, manual_duty
	input  logic [1:0]   s_axis_tuser,  // command
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [31:0]  m_axis_tdata,  // drive
	output logic [2:0]   m_axis_tuser,  // status
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [2:0]   cfg_index,
	input  logic [31:0]  cfg_data
);

	ctl_state_t state_q, state_d;
	logic wait_q;

	logic [30:0] kp_q, ki_q, kd_q, sep_q, db_q;
	logic signed [31:0] dmax_q, dmin_q;
	logic signed [47:0] acc_q;
	logic signed [31:0] prior_q, held_q;
	logic auto_q;

	logic signed [31:0] e_q;
	logic [31:0] ae_q;
	logic [15:0] ms_q;
	logic [47:0] em_q;
	logic [76:0] rlo_q;
	logic [37:0] step_q;
	logic [41:0] den_q;
	logic [56:0] num_q;
	logic signed [53:0] it_q;
	logic [52:0] pt_q, g_q;
	logic signed [63:0] dt_q;
	status_t res_q;

	logic out_valid_q;
	logic [31:0] out_drive_q;
	status_t out_status_q;

	logic in_fire;
	cmd_t cmd_in;
	logic signed [31:0] tgt_in, meas_in, duty_in, e_in, duty_c1;
	logic [15:0] iv_in;
	logic signed [32:0] diff_in;
	logic [31:0] ae_in;
	logic held_in;

	logic mul_start, mul_done, div_start, div_done, is_mul, is_div;
	logic [MUL_A_W-1:0] mul_a;
	logic [MUL_B_W-1:0] mul_b;
	logic [MUL_P_W-1:0] mul_p;
	logic [DIV_N_W-1:0] div_num, div_quo;
	logic [DIV_D_W-1:0] div_den;
	logic [MAG_W-1:0] cap;
	logic [88:0] rsum;

	logic [31:0] admax;
	logic [47:0] acc_mag;
	logic signed [32:0] de;
	logic [32:0] ade;
	logic signed [48:0] imax, step_s, isum, ic1, ic2, bc_s;
	logic signed [47:0] isat;
	logic signed [53:0] pt_s;
	logic signed [64:0] drv, d1;
	logic up, lo, need_bc;
	logic signed [31:0] fin;

	assign tgt_in = s_axis_tdata[31:0];
	assign meas_in = s_axis_tdata[63:32];
	assign iv_in = s_axis_tdata[79:64];
	assign duty_in = s_axis_tdata[111:80];
	assign cmd_in = cmd_t'(s_axis_tuser);
	assign in_fire = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;

	assign diff_in = {tgt_in[31], tgt_in} - {meas_in[31], meas_in};
	assign e_in = (diff_in[32] != diff_in[31]) ?
		(diff_in[32] ? {1'b1, 31'b0} : {1'b0, {31{1'b1}}}) : diff_in[31:0];
	assign ae_in = e_in[31] ? (~e_in + 32'd1) : e_in;
	assign held_in = !auto_q || (ae_in < {1'b0, db_q});
	assign duty_c1 = (duty_in > dmax_q) ? dmax_q : duty_in;

	assign admax = dmax_q[31] ? (~dmax_q + 32'd1) : dmax_q;
	assign acc_mag = acc_q[47] ? (~acc_q + 48'd1) : acc_q;
	assign de = {e_q[31], e_q} - {prior_q[31], prior_q};
	assign ade = de[32] ? (~de + 33'd1) : de;
	assign cap = gain_cap(mul_p);
	assign rsum = {mul_p[56:0], 32'b0} + {12'b0, rlo_q};

	assign is_mul = (state_q == ST_EM) || (state_q == ST_RLO) || (state_q == ST_RHI) ||
		(state_q == ST_KI1K) || (state_q == ST_DM1K) || (state_q == ST_IT) ||
		(state_q == ST_PT) || (state_q == ST_DG) || (state_q == ST_D1K);
	assign is_div = (state_q == ST_IMAX) || (state_q == ST_DDIV);
	assign mul_start = is_mul && !wait_q;
	assign div_start = is_div && !wait_q;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		div_num = '0;
		div_den = '0;
		unique case (state_q)
			ST_EM: begin
				mul_a = {32'b0, ae_q};
				mul_b = {16'b0, ms_q};
			end
			ST_RLO: begin
				mul_a = {19'b0, em_q[47:3]};
				mul_b = K1000_LO;
			end
			ST_RHI: begin
				mul_a = {19'b0, em_q[47:3]};
				mul_b = K1000_HI;
			end
			ST_KI1K: begin
				mul_a = {33'b0, ki_q};
				mul_b = {16'b0, MS_PER_S};
			end
			ST_DM1K: begin
				mul_a = {32'b0, admax};
				mul_b = {16'b0, MS_PER_S};
			end
			ST_IT: begin
				mul_a = {16'b0, acc_mag};
				mul_b = {1'b0, ki_q};
			end
			ST_PT: begin
				mul_a = {32'b0, ae_q};
				mul_b = {1'b0, kp_q};
			end
			ST_DG: begin
				mul_a = {31'b0, ade};
				mul_b = {1'b0, kd_q};
			end
			ST_D1K: begin
				mul_a = {11'b0, g_q};
				mul_b = {16'b0, MS_PER_S};
			end
			ST_IMAX: begin
				div_num = {7'b0, num_q};
				div_den = den_q;
			end
			ST_DDIV: begin
				div_num = mul_p[63:0];
				div_den = {26'b0, ms_q};
			end
			default: ;
		endcase
	end

	pdz_mul u_mul (
		.clk(clk), .arst_n(arst_n), .start(mul_start), .a(mul_a), .b(mul_b),
		.done(mul_done), .prod(mul_p)
	);

	pdz_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num(div_num), .den(div_den),
		.done(div_done), .quo(div_quo)
	);

	always_comb begin
		imax = {8'b0, div_quo[40:0]};
		if (dmax_q[31])
			imax = -imax;
		step_s = {11'b0, step_q};
		if (e_q[31])
			step_s = -step_s;
		isum = {acc_q[47], acc_q} + step_s;
		isat = sat48(isum);
		ic1 = {isat[47], isat};
		if (ic1 > imax)
			ic1 = imax;
		ic2 = ic1;
		if (ic2 < -imax)
			ic2 = -imax;
		bc_s = {12'b0, step_q[37:1]};
		if (!e_q[31])
			bc_s = -bc_s;
		pt_s = e_q[31] ? -$signed({1'b0, pt_q}) : $signed({1'b0, pt_q});
		drv = 65'(pt_s) + 65'(it_q) + 65'(dt_q);
		up = drv > 65'(dmax_q);
		d1 = up ? 65'(dmax_q) : drv;
		lo = d1 < 65'(dmin_q);
		fin = lo ? dmin_q : d1[31:0];
		need_bc = (up && !e_q[31] && (e_q != 32'sd0)) || (lo && e_q[31]);
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_fire)
					state_d = (cmd_in != CMD_COMPUTE || held_in) ? ST_DONE : ST_EM;
			end
			ST_EM: if (mul_done) state_d = ST_RLO;
			ST_RLO: if (mul_done) state_d = ST_RHI;
			ST_RHI: if (mul_done) state_d = (ae_q < {1'b0, sep_q}) ? ST_KI1K : ST_IT;
			ST_KI1K: if (mul_done) state_d = ST_DM1K;
			ST_DM1K: if (mul_done) state_d = ST_IMAX;
			ST_IMAX: if (div_done) state_d = ST_IT;
			ST_IT: if (mul_done) state_d = ST_PT;
			ST_PT: if (mul_done) state_d = ST_DG;
			ST_DG: if (mul_done) state_d = ST_D1K;
			ST_D1K: if (mul_done) state_d = ST_DDIV;
			ST_DDIV: if (div_done) state_d = ST_SUM;
			ST_SUM: state_d = need_bc ? ST_BC : ST_DONE;
			ST_BC: state_d = ST_DONE;
			ST_DONE: if (!out_valid_q || m_axis_tready) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			wait_q <= 1'b0;
			out_valid_q <= 1'b0;
			kp_q <= '0;
			ki_q <= '0;
			kd_q <= '0;
			dmax_q <= DMAX_RESET;
			dmin_q <= '0;
			sep_q <= SEP_RESET;
			db_q <= DB_RESET;
			acc_q <= '0;
			prior_q <= '0;
			held_q <= '0;
			auto_q <= 1'b1;
		end else begin
			state_q <= state_d;
			if (mul_done || div_done)
				wait_q <= 1'b0;
			else if (mul_start || div_start)
				wait_q <= 1'b1;

			if (state_q == ST_DONE && (!out_valid_q || m_axis_tready))
				out_valid_q <= 1'b1;
			else if (m_axis_tready)
				out_valid_q <= 1'b0;

			if (cfg_valid) begin
				case (cfg_reg_t'(cfg_index))
					REG_PROP_GAIN: begin
						kp_q <= cfg_data[30:0];
						acc_q <= '0;
					end
					REG_INTEG_GAIN: begin
						ki_q <= cfg_data[30:0];
						acc_q <= '0;
					end
					REG_DERIV_GAIN: begin
						kd_q <= cfg_data[30:0];
						acc_q <= '0;
					end
					REG_DRIVE_MAX: dmax_q <= cfg_data;
					REG_DRIVE_MIN: dmin_q <= cfg_data;
					REG_SEP_LIMIT: sep_q <= cfg_data[30:0];
					REG_DEAD_BAND: db_q <= cfg_data[30:0];
					default: ;
				endcase
			end

			if (state_q == ST_IDLE && in_fire) begin
				case (cmd_in)
					CMD_MANUAL_DUTY: begin
						auto_q <= 1'b0;
						held_q <= (duty_c1 < dmin_q) ? dmin_q : duty_c1;
					end
					CMD_AUTO_RESET: begin
						auto_q <= 1'b1;
						acc_q <= '0;
						prior_q <= '0;
						held_q <= '0;
					end
					CMD_MANUAL: begin
						auto_q <= 1'b0;
						held_q <= '0;
					end
					default: ;
				endcase
			end
			if (state_q == ST_RHI && mul_done && !(ae_q < {1'b0, sep_q}))
				acc_q <= '0;
			if (state_q == ST_IMAX && div_done)
				acc_q <= ic2[47:0];
			if (state_q == ST_SUM) begin
				held_q <= fin;
				prior_q <= e_q;
			end
			if (state_q == ST_BC)
				acc_q <= sat48({acc_q[47], acc_q} + bc_s);
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_fire) begin
			e_q <= e_in;
			ae_q <= ae_in;
			ms_q <= (iv_in == 16'd0) ? MS_DEFAULT : iv_in;
			if (cmd_in != CMD_COMPUTE)
				res_q <= STS_APPLIED;
			else if (!auto_q)
				res_q <= STS_HELD_MANUAL;
			else
				res_q <= STS_HELD_DEAD;
		end
		if (state_q == ST_EM && mul_done)
			em_q <= mul_p[47:0];
		if (state_q == ST_RLO && mul_done)
			rlo_q <= mul_p[76:0];
		if (state_q == ST_RHI && mul_done)
			step_q <= rsum[88:51];
		if (state_q == ST_KI1K && mul_done)
			den_q <= mul_p[41:0] + (42'd1 << FRAC_BITS);
		if (state_q == ST_DM1K && mul_done)
			num_q <= {mul_p[40:0], {FRAC_BITS{1'b0}}};
		if (state_q == ST_IT && mul_done)
			it_q <= acc_q[47] ? -$signed({1'b0, cap}) : $signed({1'b0, cap});
		if (state_q == ST_PT && mul_done)
			pt_q <= cap;
		if (state_q == ST_DG && mul_done)
			g_q <= cap;
		if (state_q == ST_DDIV && div_done)
			dt_q <= de[32] ? -$signed({1'b0, div_quo[62:0]}) : $signed({1'b0, div_quo[62:0]});
		if (state_q == ST_SUM)
			res_q <= (up || lo) ? STS_CLAMPED : STS_COMPUTED;
		if (state_q == ST_DONE && (!out_valid_q || m_axis_tready)) begin
			out_drive_q <= held_q;
			out_status_q <= res_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = out_drive_q;
	assign m_axis_tuser = out_status_q;

	a_unit_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(mul_start && div_start))
		else $error("multiplier and divider started together");

	a_busy_after_word: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input taken while a word is in work");

	a_done_emits: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DONE && !out_valid_q |=> m_axis_tvalid)
		else $error("finished word not presented");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tuser <= STS_APPLIED)
		else $error("status out of range");

endmodule
